// File: rtl/tlpq_pkg.sv
`timescale 1ns / 1ps

package tlpq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CLS_W       = 2;
  localparam int VALUE_W     = 32;

  typedef logic [CLS_W-1:0] cls_t;

  localparam cls_t CLS_HIGH   = 2'd0;
  localparam cls_t CLS_MEDIUM = 2'd1;
  localparam cls_t CLS_LOW    = 2'd2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_RESP
  } state_t;

endpackage

// File: rtl/three_level_priority_queue.sv
`timescale 1ns / 1ps
// Sequence: an accepted request moves through ST_HEAD, where the registered pop read
// is captured, then ST_RESP, where the head read is loaded into the result register;
// no new request is taken until then, and a stalled result holds the block in ST_RESP.
// Reset (rst_n low, synchronous): clears read/write pointers, fill counts, state and
// output valid. Memory contents are not cleared; no clearing pass is needed.
module three_level_priority_queue #(
  parameter int CLASS_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // item_value[31:0], item_priority[33:32], zero pad
  input  logic [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // popped_value[31:0], popped_priority[33:32],
                                  // head_value[65:34], head_priority[67:66],
                                  // queue_empty[68], total_count[74:69], high_count[79:75],
                                  // medium_count[84:80], low_count[89:85], zero pad
  output logic [0:0]  out_tuser   // ok[0]
);

  import tlpq_pkg::*;

  localparam int AW = $clog2(CLASS_DEPTH);
  localparam int CW = $clog2(CLASS_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [AW-1:0] rd_ptr_r [NUM_CLASSES];
  logic [AW-1:0] wr_ptr_r [NUM_CLASSES];
  logic [CW-1:0] fill_r   [NUM_CLASSES];

  logic [DATA_WIDTH-1:0] rdata [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] ram_we;
  logic [DATA_WIDTH-1:0]  wdata;

  logic                  ok_r;
  logic                  pop_r;
  cls_t                  pcls_r;
  logic [DATA_WIDTH-1:0] pval_r;

  logic        out_valid_r;
  logic [95:0] out_tdata_r;
  logic        out_ok_r;

  logic       accept;
  logic       is_pop;
  cls_t       push_cls;
  cls_t       top_cls;
  logic       top_valid;
  cls_t       op_cls;
  logic       op_ok;
  logic       load_out;

  logic [31:0]   in_value;
  logic [1:0]    in_prio;
  logic [DATA_WIDTH+31:0] wdata_ext;
  logic [DATA_WIDTH+31:0] pval_ext;
  logic [DATA_WIDTH+31:0] hval_ext;
  logic [DATA_WIDTH-1:0]  hval;
  logic [CW+1:0]          total;
  logic [CW+6:0]          total_ext;
  logic [CW+4:0]          hc_ext, mc_ext, lc_ext;

  assign in_value = in_tdata[31:0];
  assign in_prio  = in_tdata[33:32];

  genvar k;
  generate
    for (k = 0; k < NUM_CLASSES; k++) begin : g_store
      tlpq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(CLASS_DEPTH)
      ) u_ram (
        .clk  (clk),
        .we   (ram_we[k]),
        .waddr(wr_ptr_r[k]),
        .wdata(wdata),
        .raddr(rd_ptr_r[k]),
        .rdata(rdata[k])
      );
    end
  endgenerate

  always_comb begin
    top_valid = 1'b1;
    if (fill_r[0] != '0) begin
      top_cls = CLS_HIGH;
    end else if (fill_r[1] != '0) begin
      top_cls = CLS_MEDIUM;
    end else if (fill_r[2] != '0) begin
      top_cls = CLS_LOW;
    end else begin
      top_cls   = CLS_HIGH;
      top_valid = 1'b0;
    end
  end

  assign is_pop   = (in_tuser[0] == REQ_POP);
  assign push_cls = (in_prio == 2'd3) ? CLS_LOW : cls_t'(in_prio);
  assign op_cls   = is_pop ? top_cls : push_cls;
  assign op_ok    = is_pop ? top_valid : (fill_r[op_cls] != CW'(CLASS_DEPTH));

  assign wdata_ext = {{DATA_WIDTH{1'b0}}, in_value};
  assign wdata     = wdata_ext[DATA_WIDTH-1:0];

  always_comb begin
    ram_we = '0;
    if (accept && !is_pop && op_ok) begin
      ram_we[op_cls] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    accept    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // pointer and fill update at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        fill_r[i]   <= '0;
      end
    end else if (accept && op_ok) begin
      if (is_pop) begin
        rd_ptr_r[op_cls] <= (rd_ptr_r[op_cls] == AW'(CLASS_DEPTH - 1)) ? '0 :
                            rd_ptr_r[op_cls] + 1'b1;
        fill_r[op_cls]   <= fill_r[op_cls] - 1'b1;
      end else begin
        wr_ptr_r[op_cls] <= (wr_ptr_r[op_cls] == AW'(CLASS_DEPTH - 1)) ? '0 :
                            wr_ptr_r[op_cls] + 1'b1;
        fill_r[op_cls]   <= fill_r[op_cls] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r   <= op_ok;
      pop_r  <= is_pop && op_ok;
      pcls_r <= op_cls;
    end
    if (state_r == ST_HEAD) begin
      pval_r <= pop_r ? rdata[pcls_r] : '0;
    end
  end

  assign hval      = top_valid ? rdata[top_cls] : '0;
  assign pval_ext  = {32'd0, pval_r};
  assign hval_ext  = {32'd0, hval};
  assign total     = (CW+2)'(fill_r[0]) + (CW+2)'(fill_r[1]) + (CW+2)'(fill_r[2]);
  assign total_ext = {5'd0, total};
  assign hc_ext    = {5'd0, fill_r[0]};
  assign mc_ext    = {5'd0, fill_r[1]};
  assign lc_ext    = {5'd0, fill_r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok_r    <= ok_r;
      out_tdata_r <= {6'd0,
                      lc_ext[4:0],
                      mc_ext[4:0],
                      hc_ext[4:0],
                      total_ext[5:0],
                      !top_valid,
                      top_valid ? top_cls : CLS_HIGH,
                      hval_ext[31:0],
                      pop_r ? pcls_r : CLS_HIGH,
                      pval_ext[31:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_ok_r;

endmodule

// File: rtl/tlpq_ram.sv
`timescale 1ns / 1ps

module tlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: tb/tlpq_result_checker.sv
`timescale 1ns / 1ps

module tlpq_result_checker #(
  parameter int CLASS_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // item_value[31:0], item_priority[33:32], zero pad
  input  logic [0:0]  in_tuser,   // req_type[0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,  // popped_value[31:0], popped_priority[33:32],
                                  // head_value[65:34], head_priority[67:66],
                                  // queue_empty[68], total_count[74:69], high_count[79:75],
                                  // medium_count[84:80], low_count[89:85], zero pad
  input  logic [0:0]  out_tuser,  // ok[0]
  output int          pending_count,
  output int          error_count
);

  import tlpq_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [31:0] popped_value;
    cls_t        popped_cls;
    logic [31:0] head_value;
    cls_t        head_cls;
    logic        empty;
    logic [5:0]  total;
    logic [4:0]  high_fill;
    logic [4:0]  medium_fill;
    logic [4:0]  low_fill;
  } queue_status_t;

  logic [31:0] class_mem [NUM_CLASSES][CLASS_DEPTH];
  int          rd_ptr    [NUM_CLASSES];
  int          wr_ptr    [NUM_CLASSES];
  int          fill      [NUM_CLASSES];

  queue_status_t expected_status [$];

  function automatic int highest_occupied();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (fill[c] != 0) return c;
    end
    return NUM_CLASSES;
  endfunction

  task automatic predict_status(input logic req, input logic [31:0] value,
                                input cls_t cls_in, output queue_status_t st);
    int c;
    int total;
    st = '0;
    if (req == REQ_PUSH) begin
      c = (cls_in > CLS_LOW) ? int'(CLS_LOW) : int'(cls_in);
      if (fill[c] < CLASS_DEPTH) begin
        class_mem[c][wr_ptr[c]] = value;
        wr_ptr[c] = (wr_ptr[c] + 1) % CLASS_DEPTH;
        fill[c]++;
        st.ok = 1'b1;
      end
    end else begin
      c = highest_occupied();
      if (c < NUM_CLASSES) begin
        st.popped_value = class_mem[c][rd_ptr[c]];
        st.popped_cls   = cls_t'(c);
        rd_ptr[c] = (rd_ptr[c] + 1) % CLASS_DEPTH;
        fill[c]--;
        st.ok = 1'b1;
      end
    end
    c = highest_occupied();
    if (c < NUM_CLASSES) begin
      st.head_value = class_mem[c][rd_ptr[c]];
      st.head_cls   = cls_t'(c);
    end
    total          = fill[0] + fill[1] + fill[2];
    st.empty       = (total == 0);
    st.total       = 6'(total);
    st.high_fill   = 5'(fill[0]);
    st.medium_fill = 5'(fill[1]);
    st.low_fill    = 5'(fill[2]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_status_t want;
    queue_status_t got;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        rd_ptr[c] = 0;
        wr_ptr[c] = 0;
        fill[c]   = 0;
      end
      expected_status.delete();
      error_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_status(in_tuser[0], in_tdata[31:0], cls_t'(in_tdata[33:32]), want);
        expected_status.insert(expected_status.size(), want);
      end
      if (out_tvalid && out_tready) begin
        got.ok           = out_tuser[0];
        got.popped_value = out_tdata[31:0];
        got.popped_cls   = out_tdata[33:32];
        got.head_value   = out_tdata[65:34];
        got.head_cls     = out_tdata[67:66];
        got.empty        = out_tdata[68];
        got.total        = out_tdata[74:69];
        got.high_fill    = out_tdata[79:75];
        got.medium_fill  = out_tdata[84:80];
        got.low_fill     = out_tdata[89:85];
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual %0h",
                   $time, out_tdata);
          error_count++;
        end else begin
          want = expected_status[0];
          expected_status.delete(0);
          check_field("ok",              want.ok,           got.ok);
          check_field("popped_value",    want.popped_value, got.popped_value);
          check_field("popped_priority", want.popped_cls,   got.popped_cls);
          check_field("head_value",      want.head_value,   got.head_value);
          check_field("head_priority",   want.head_cls,     got.head_cls);
          check_field("queue_empty",     want.empty,        got.empty);
          check_field("total_count",     want.total,        got.total);
          check_field("high_count",      want.high_fill,    got.high_fill);
          check_field("medium_count",    want.medium_fill,  got.medium_fill);
          check_field("low_count",       want.low_fill,     got.low_fill);
        end
      end
    end
    pending_count <= expected_status.size();
  end

endmodule

// File: tb/three_level_priority_queue_tb.sv
`timescale 1ns / 1ps

module three_level_priority_queue_tb;
  import tlpq_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic [0:0]  out_tuser;
  int          pending_count;
  int          error_count;
  int          cycle_count = 0;

  three_level_priority_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tlpq_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .pending_count (pending_count),
    .error_count   (error_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** three_level_priority_queue: FAILED **");
      $finish;
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 1;
    if (r < 18) return $urandom_range(2, 5);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic req, input logic [31:0] value, input cls_t cls);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, cls, value};
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    out_tready = 1'b1;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 100)) @(posedge clk);
      end else begin
        out_tready <= 1'($urandom_range(0, 1));
        repeat (stall_len()) @(posedge clk);
      end
    end
  end

  initial begin
    int   random_sent;
    int   push_pct;
    int   favour;
    int   phase_len;
    bit   no_gaps;
    logic req;
    cls_t cls;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pop on empty, one push per class code, strict order on pop
    send_request(REQ_POP,  32'hFFFF_FFFF, 2'd3);
    send_request(REQ_PUSH, 32'h8000_0000, CLS_HIGH);
    send_request(REQ_PUSH, 32'h7FFF_FFFF, CLS_MEDIUM);
    send_request(REQ_PUSH, 32'hFFFF_FFFF, 2'd3);
    send_request(REQ_PUSH, 32'h0000_0000, CLS_LOW);
    send_request(REQ_POP,  32'h0000_0000, CLS_HIGH);
    send_request(REQ_POP,  32'h0000_0000, CLS_HIGH);
    // fill the low class, then push past full
    repeat (14) send_request(REQ_PUSH, $urandom, CLS_LOW);
    send_request(REQ_PUSH, 32'h1234_5678, 2'd3);
    send_request(REQ_PUSH, 32'h8765_4321, CLS_LOW);
    send_request(REQ_POP,  32'h0000_0000, CLS_LOW);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 15;
        1:       push_pct = 50;
        2:       push_pct = 85;
        default: push_pct = 97;
      endcase
      favour    = $urandom_range(0, 4);
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 80);
      repeat (phase_len) begin
        req = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        cls = (favour == 4) ? cls_t'($urandom_range(0, 3)) : cls_t'(favour);
        send_request(req, pick_value(), cls);
        random_sent++;
        if (random_sent == RANDOM_ITEMS / 2) drain_results();
        else if (!no_gaps) idle_for(sender_gap());
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** three_level_priority_queue: PASSED **");
    end else begin
      $display("** three_level_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tlpq_pkg.sv
rtl/tlpq_ram.sv
rtl/three_level_priority_queue.sv
tb/tlpq_result_checker.sv
tb/three_level_priority_queue_tb.sv
